// ----- hdl/srtq_pkg.sv -----
// Shared types and constants for the two-level SRT quantum scheduler.
`timescale 1ns / 1ps
`default_nettype none
package srtq_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int ID_BITS_DEF     = 8;
  localparam int SLOT_BITS_DEF   = 16;

  localparam logic [7:0] QUANTUM_RESET = 8'd8;

  // Input beat codes.
  localparam logic MODE_ARRIVE = 1'b0;
  localparam logic MODE_TICK   = 1'b1;
  localparam logic PRIO_HIGH   = 1'b0;
  localparam logic PRIO_LOW    = 1'b1;

  typedef enum logic [1:0] {
    Q_HOLD,
    Q_PUSH,
    Q_POP
  } q_op_t;

  typedef enum logic {
    ST_IDLE,
    ST_FINISH
  } sched_state_t;

  typedef struct packed {
    q_op_t op;
    logic  prev_after;
  } cell_ctrl_t;

endpackage
`default_nettype wire

// ----- hdl/srtq_cell.sv -----
// One queue cell: holds one entry and trades it with its neighbors.
`timescale 1ns / 1ps
`default_nettype none
module srtq_cell
  import srtq_pkg::*;
#(
  parameter int ID_BITS   = ID_BITS_DEF,
  parameter int SLOT_BITS = SLOT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire cell_ctrl_t           ctrl,
  input  wire logic                 occupied,
  input  wire logic [SLOT_BITS-1:0] key_slots,
  input  wire logic [ID_BITS-1:0]   key_id,
  input  wire logic [SLOT_BITS-1:0] prev_slots,
  input  wire logic [ID_BITS-1:0]   prev_id,
  input  wire logic [SLOT_BITS-1:0] next_slots,
  input  wire logic [ID_BITS-1:0]   next_id,
  output logic [SLOT_BITS-1:0]      slots,
  output logic [ID_BITS-1:0]        id,
  output logic                      after
);

  // New key sorts behind this entry (ties stay in arrival order).
  assign after = occupied && (slots <= key_slots);

  always_ff @(posedge clk) begin
    case (ctrl.op)
      Q_PUSH: begin
        if (!after) begin
          if (ctrl.prev_after) begin
            slots <= key_slots;
            id    <= key_id;
          end else begin
            slots <= prev_slots;
            id    <= prev_id;
          end
        end
      end
      Q_POP: begin
        slots <= next_slots;
        id    <= next_id;
      end
      default: begin
      end
    endcase
  end

endmodule
`default_nettype wire

// ----- hdl/srtq_queue.sv -----
// Sorted job queue built as a chain of cells with an occupancy count.
`timescale 1ns / 1ps
`default_nettype none
module srtq_queue
  import srtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int SLOT_BITS   = SLOT_BITS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire q_op_t                op,
  input  wire logic [SLOT_BITS-1:0] key_slots,
  input  wire logic [ID_BITS-1:0]   key_id,
  output logic [SLOT_BITS-1:0]      head_slots,
  output logic [ID_BITS-1:0]        head_id,
  output logic                      empty,
  output logic                      full
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [CNT_W-1:0]     count;
  logic [SLOT_BITS-1:0] cell_slots [QUEUE_DEPTH];
  logic [ID_BITS-1:0]   cell_id    [QUEUE_DEPTH];
  logic                 cell_after [QUEUE_DEPTH];

  assign empty      = (count == '0);
  assign full       = (count == CNT_W'(QUEUE_DEPTH));
  assign head_slots = cell_slots[0];
  assign head_id    = cell_id[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else begin
      case (op)
        Q_PUSH:  count <= count + 1'b1;
        Q_POP:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    cell_ctrl_t           ctrl;
    logic                 p_after;
    logic [SLOT_BITS-1:0] p_slots, n_slots;
    logic [ID_BITS-1:0]   p_id, n_id;

    if (i == 0) begin : g_first
      assign p_after = 1'b1;
      assign p_slots = key_slots;
      assign p_id    = key_id;
    end else begin : g_mid
      assign p_after = cell_after[i-1];
      assign p_slots = cell_slots[i-1];
      assign p_id    = cell_id[i-1];
    end

    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign n_slots = cell_slots[i];
      assign n_id    = cell_id[i];
    end else begin : g_inner
      assign n_slots = cell_slots[i+1];
      assign n_id    = cell_id[i+1];
    end

    assign ctrl = '{op: op, prev_after: p_after};

    srtq_cell #(
      .ID_BITS   (ID_BITS),
      .SLOT_BITS (SLOT_BITS)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count > CNT_W'(i)),
      .key_slots  (key_slots),
      .key_id     (key_id),
      .prev_slots (p_slots),
      .prev_id    (p_id),
      .next_slots (n_slots),
      .next_id    (n_id),
      .slots      (cell_slots[i]),
      .id         (cell_id[i]),
      .after      (cell_after[i])
    );
  end

endmodule
`default_nettype wire

// ----- hdl/two_level_srt_quantum_scheduler_unit.sv -----
// Top level of the two-level shortest-remaining-time quantum scheduler.
`timescale 1ns / 1ps
`default_nettype none
// Non-preemptive scheduler with a high and a low priority queue, each kept
// sorted by remaining slots (equal keys stay in arrival order). An input beat
// with mode 0 is an arrival: the job goes into the queue picked by
// job_priority, or is dropped with the sticky dropped_flag set when that queue
// is full. An arrival produces no output beat. An input beat with mode 1 is
// a tick: if the machine is idle the head of the high queue (else the low
// queue) is dispatched for min(quantum, remaining) slots; when its slot
// budget runs out the leftover work is requeued; then one report beat goes
// out and time advances. A tick dispatches in ST_IDLE at the accepting edge;
// ST_FINISH then does the completion check, requeue and report once the
// output side no longer holds an earlier report beat under stall. Each queue
// is a chain of QUEUE_DEPTH cells; a push or pop shifts the whole chain at
// once, so no clearing pass follows reset. A quantum of zero behaves as one.
// Write quantum only while the block is idle.
module two_level_srt_quantum_scheduler_unit
  import srtq_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  parameter int ID_BITS     = ID_BITS_DEF,
  parameter int SLOT_BITS   = SLOT_BITS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        quantum_we,
  input  wire logic [7:0]  quantum_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        mode,
  input  wire logic [7:0]  job_id,
  input  wire logic        job_priority,
  input  wire logic [15:0] job_slots,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      slot_time,
  output logic             running_valid,
  output logic [7:0]       running_job,
  output logic             all_idle,
  output logic             dropped_flag
);

  sched_state_t         state, state_next;
  logic [7:0]           quantum;
  logic                 busy, busy_next;
  logic [ID_BITS-1:0]   cur_job, cur_job_next;
  logic                 cur_low, cur_low_next;
  // Work left once the current slot budget is spent.
  logic [SLOT_BITS-1:0] rem_left, rem_left_next;
  logic [31:0]          deadline, deadline_next;
  logic [31:0]          now, now_next;
  logic                 drop_seen, drop_seen_next;
  logic                 out_valid_next;
  logic [31:0]          slot_time_next;
  logic                 running_valid_next;
  logic [7:0]           running_job_next;
  logic                 all_idle_next;
  logic                 dropped_flag_next;

  q_op_t                hq_op, lq_op;
  logic [SLOT_BITS-1:0] key_slots;
  logic [ID_BITS-1:0]   key_id;
  logic [SLOT_BITS-1:0] hq_head_slots, lq_head_slots;
  logic [ID_BITS-1:0]   hq_head_id, lq_head_id;
  logic                 hq_empty, lq_empty, hq_full, lq_full;

  logic                 accept;
  logic                 pick_low;
  logic [SLOT_BITS-1:0] pick_slots;
  logic [31:0]          q_eff, rem_ext, run;
  logic                 done, requeue, requeue_full, busy_after;

  srtq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .SLOT_BITS   (SLOT_BITS)
  ) u_high_q (
    .clk        (clk),
    .rst        (rst),
    .op         (hq_op),
    .key_slots  (key_slots),
    .key_id     (key_id),
    .head_slots (hq_head_slots),
    .head_id    (hq_head_id),
    .empty      (hq_empty),
    .full       (hq_full)
  );

  srtq_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .ID_BITS     (ID_BITS),
    .SLOT_BITS   (SLOT_BITS)
  ) u_low_q (
    .clk        (clk),
    .rst        (rst),
    .op         (lq_op),
    .key_slots  (key_slots),
    .key_id     (key_id),
    .head_slots (lq_head_slots),
    .head_id    (lq_head_id),
    .empty      (lq_empty),
    .full       (lq_full)
  );

  assign in_stall = (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;

  // Dispatch datapath: high queue wins while it holds anything.
  assign pick_low   = hq_empty;
  assign pick_slots = pick_low ? lq_head_slots : hq_head_slots;
  assign q_eff      = (quantum == 8'd0) ? 32'd1 : 32'(quantum);
  assign rem_ext    = 32'(pick_slots);
  assign run        = (q_eff < rem_ext) ? q_eff : rem_ext;

  // Completion datapath, used in the finish cycle.
  assign done         = busy && (now == deadline);
  assign requeue      = done && (rem_left != '0);
  assign requeue_full = cur_low ? lq_full : hq_full;
  assign busy_after   = busy && !done;

  always_comb begin
    state_next         = state;
    busy_next          = busy;
    cur_job_next       = cur_job;
    cur_low_next       = cur_low;
    rem_left_next      = rem_left;
    deadline_next      = deadline;
    now_next           = now;
    drop_seen_next     = drop_seen;
    out_valid_next     = out_valid && out_stall;
    slot_time_next     = slot_time;
    running_valid_next = running_valid;
    running_job_next   = running_job;
    all_idle_next      = all_idle;
    dropped_flag_next  = dropped_flag;
    hq_op              = Q_HOLD;
    lq_op              = Q_HOLD;
    key_slots          = SLOT_BITS'(job_slots);
    key_id             = ID_BITS'(job_id);

    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (mode == MODE_ARRIVE) begin
            // Arrival: insert in place, or drop on a full queue.
            if ((job_priority == PRIO_LOW) ? lq_full : hq_full) begin
              drop_seen_next = 1'b1;
            end else if (job_priority == PRIO_LOW) begin
              lq_op = Q_PUSH;
            end else begin
              hq_op = Q_PUSH;
            end
          end else begin
            if (!busy && !(hq_empty && lq_empty)) begin
              if (pick_low) begin
                lq_op = Q_POP;
              end else begin
                hq_op = Q_POP;
              end
              cur_job_next  = pick_low ? lq_head_id : hq_head_id;
              cur_low_next  = pick_low;
              busy_next     = 1'b1;
              deadline_next = now + run;
              rem_left_next = SLOT_BITS'(rem_ext - run);
            end
            state_next = ST_FINISH;
          end
        end
      end
      ST_FINISH: begin
        // Hold until the report register is free.
        if (!(out_valid && out_stall)) begin
          key_slots = rem_left;
          key_id    = cur_job;
          if (requeue) begin
            if (requeue_full) begin
              drop_seen_next = 1'b1;
            end else if (cur_low) begin
              lq_op = Q_PUSH;
            end else begin
              hq_op = Q_PUSH;
            end
          end
          busy_next          = busy_after;
          out_valid_next     = 1'b1;
          slot_time_next     = now;
          running_valid_next = busy_after;
          running_job_next   = busy_after ? 8'(cur_job) : 8'd0;
          all_idle_next      = !busy_after && hq_empty && lq_empty && !requeue;
          dropped_flag_next  = drop_seen || (requeue && requeue_full);
          now_next           = now + 32'd1;
          state_next         = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      busy      <= 1'b0;
      cur_job   <= '0;
      cur_low   <= 1'b0;
      rem_left  <= '0;
      deadline  <= '0;
      now       <= '0;
      drop_seen <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      busy      <= busy_next;
      cur_job   <= cur_job_next;
      cur_low   <= cur_low_next;
      rem_left  <= rem_left_next;
      deadline  <= deadline_next;
      now       <= now_next;
      drop_seen <= drop_seen_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      quantum <= QUANTUM_RESET;
    end else if (quantum_we) begin
      quantum <= quantum_data;
    end
  end

  // Report payload, no reset needed.
  always_ff @(posedge clk) begin
    slot_time     <= slot_time_next;
    running_valid <= running_valid_next;
    running_job   <= running_job_next;
    all_idle      <= all_idle_next;
    dropped_flag  <= dropped_flag_next;
  end

endmodule
`default_nettype wire
